// ===== rtl/core/ata_tfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: shared package
// Payload structs, register codes, sequencer steps and address constants.
// ----------------------------------------------------------------------------
package ata_tfcs_pkg;

  // Request and response payloads
  typedef struct packed {
    logic [1:0]  drive_number;
    logic        transfer_direction;
    logic [31:0] block_address;
    logic [7:0]  sector_count;
  } req_t;

  typedef struct packed {
    logic       bus_channel;
    logic [3:0] register_index;
    logic [7:0] register_data;
    logic       last_write;
  } rsp_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNEL_MAP = 2'd0,
    CFG_SLAVE_MAP   = 2'd1,
    CFG_LBA_MAP     = 2'd2
  } cfg_idx_e;

  localparam logic [3:0] CHANNEL_MAP_RST = 4'd12;
  localparam logic [3:0] SLAVE_MAP_RST   = 4'd10;
  localparam logic [3:0] LBA_MAP_RST     = 4'd15;

  // Logical task-file register codes
  typedef enum logic [3:0] {
    REG_COUNT0  = 4'd2,
    REG_LBA0    = 4'd3,
    REG_LBA1    = 4'd4,
    REG_LBA2    = 4'd5,
    REG_DEVSEL  = 4'd6,
    REG_COMMAND = 4'd7,
    REG_COUNT1  = 4'd8,
    REG_LBA3    = 4'd9,
    REG_LBA4    = 4'd10,
    REG_LBA5    = 4'd11,
    REG_CONTROL = 4'd12
  } reg_idx_e;

  // Write sequence, in bus order
  typedef enum logic [3:0] {
    STEP_CTRL,
    STEP_DEVSEL,
    STEP_CNT_HI,
    STEP_LBA3,
    STEP_LBA4,
    STEP_LBA5,
    STEP_CNT_LO,
    STEP_LBA0,
    STEP_LBA1,
    STEP_LBA2,
    STEP_CMD
  } step_e;

  // Register byte values
  localparam logic [7:0] CONTROL_NIEN  = 8'h02;
  localparam logic [7:0] DEVSEL_CHS    = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA    = 8'hE0;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_EXT_FLAG  = 8'h04;

  // Geometry: 63 sectors per track, 16 heads. Quotient by 63 for a 28-bit
  // address is (n * ceil(2^34 / 63)) >> 34, exact over the whole range.
  localparam int         DIV63_SHIFT = 34;
  localparam logic [28:0] DIV63_MAGIC = 29'd272696337;
  localparam int         TRACK_W     = 23;

  // Work item handed from front to back
  typedef struct packed {
    logic       channel;
    logic       wide;
    logic [7:0] devsel;
    logic [7:0] addr_hi;
    logic [7:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] command;
  } desc_t;

endpackage

// ===== rtl/core/ata_tfcs_top.sv =====
// Path: a request passes the front-end stage register, the queue, the
// sequencer's work register and the response register. The sequencer
// issues one task-file write per cycle while the receiver is ready, and takes
// the next request as it issues the command write of the current one.
// Reset: drive maps return to 12, 10 and 15; queue and sequencer empty.
// ----------------------------------------------------------------------------
// ATA task-file command setup
// Turns a sector access request into the ordered task-file register writes
// that start a PIO read or write.
// ----------------------------------------------------------------------------
module ata_taskfile_command_setup_top import ata_tfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  desc_t push_desc, pop_desc;

  // Front end: mode choice and byte preparation
  ata_tfcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  // Decoupling queue
  ata_tfcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  // Write sequencer
  ata_tfcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_desc_i  (pop_desc),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/core/ata_tfcs_front.sv =====
// ----------------------------------------------------------------------------
// ATA task-file front end
// Holds the drive maps, takes a request, picks the addressing mode and
// builds the register bytes (CHS split through a reciprocal multiply).
// ----------------------------------------------------------------------------
module ata_tfcs_front import ata_tfcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output desc_t      push_desc_o
);

  logic [3:0] chan_map_q, slave_map_q, lba_map_q;

  // Drive map registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_map_q  <= CHANNEL_MAP_RST;
      slave_map_q <= SLAVE_MAP_RST;
      lba_map_q   <= LBA_MAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_MAP: chan_map_q  <= cfg_data_i;
        CFG_SLAVE_MAP:   slave_map_q <= cfg_data_i;
        CFG_LBA_MAP:     lba_map_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage register: request, drive attributes and track number
  logic               s1_valid_q, s1_valid_d;
  logic               ch_q, slave_q, capable_q, dir_q;
  logic [31:0]        lba_q;
  logic [7:0]         count_q;
  logic [TRACK_W-1:0] track_q;
  logic [56:0]        prod;
  logic               accept, push;

  // Quotient by 63 on the low 28 address bits
  assign prod = {29'd0, req_i.block_address[27:0]} * {28'd0, DIV63_MAGIC};

  assign push        = s1_valid_q && push_ready_i;
  assign req_ready_o = !s1_valid_q || push_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign s1_valid_d  = accept ? 1'b1 : (push ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q      <= chan_map_q[req_i.drive_number];
      slave_q   <= slave_map_q[req_i.drive_number];
      capable_q <= lba_map_q[req_i.drive_number];
      dir_q     <= req_i.transfer_direction;
      lba_q     <= req_i.block_address;
      count_q   <= req_i.sector_count;
      track_q   <= prod[DIV63_SHIFT +: TRACK_W];
    end
  end

  // Remainder, geometry and register bytes
  logic        wide;
  logic [28:0] track_x63;
  logic [27:0] rem_full;
  logic [7:0]  sector;
  logic [15:0] cyl;
  logic [3:0]  head;
  logic [7:0]  slave_bit;

  assign wide      = |lba_q[31:28];
  assign track_x63 = {track_q, 6'd0} - {6'd0, track_q};
  assign rem_full  = lba_q[27:0] - track_x63[27:0];
  assign sector    = {2'd0, rem_full[5:0]} + 8'd1;
  assign cyl       = track_q[19:4];
  assign head      = track_q[3:0];
  assign slave_bit = {3'd0, slave_q, 4'd0};

  always_comb begin
    push_desc_o         = '0;
    push_desc_o.channel = ch_q;
    push_desc_o.wide    = wide;
    push_desc_o.addr_hi = lba_q[31:24];
    push_desc_o.count   = count_q;
    push_desc_o.command = (dir_q ? CMD_WRITE : CMD_READ) | (wide ? CMD_EXT_FLAG : 8'd0);
    if (wide) begin
      push_desc_o.devsel = DEVSEL_LBA | slave_bit;
      push_desc_o.byte0  = lba_q[7:0];
      push_desc_o.byte1  = lba_q[15:8];
      push_desc_o.byte2  = lba_q[23:16];
    end else if (capable_q) begin
      push_desc_o.devsel = DEVSEL_LBA | slave_bit | {4'd0, lba_q[27:24]};
      push_desc_o.byte0  = lba_q[7:0];
      push_desc_o.byte1  = lba_q[15:8];
      push_desc_o.byte2  = lba_q[23:16];
    end else begin
      push_desc_o.devsel = DEVSEL_CHS | slave_bit | {4'd0, head};
      push_desc_o.byte0  = sector;
      push_desc_o.byte1  = cyl[7:0];
      push_desc_o.byte2  = cyl[15:8];
    end
  end

  assign push_valid_o = s1_valid_q;

endmodule

// ===== rtl/core/ata_tfcs_queue.sv =====
// ----------------------------------------------------------------------------
// ATA task-file work queue
// Two-entry queue of prepared requests between front end and sequencer.
// ----------------------------------------------------------------------------
module ata_tfcs_queue import ata_tfcs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  desc_t push_desc_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output desc_t pop_desc_o
);

  desc_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_desc_o   = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// ===== rtl/core/ata_tfcs_back.sv =====
// ----------------------------------------------------------------------------
// ATA task-file write sequencer
// Walks the register write order for one prepared request into a registered
// response stage, one write per cycle unless the response stage is stalled.
// ----------------------------------------------------------------------------
module ata_tfcs_back import ata_tfcs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  pop_valid_i,
  output logic  pop_ready_o,
  input  desc_t pop_desc_i,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  output rsp_t  rsp_o
);

  step_e step_q, step_d, step_next;
  logic  busy_q, busy_d;
  desc_t cur_q;
  logic  rsp_valid_q, rsp_valid_d;
  rsp_t  rsp_q, item;
  logic  out_load, fire, last_step, pop;

  assign out_load    = !rsp_valid_q || rsp_ready_i;
  assign fire        = busy_q && out_load;
  assign last_step   = step_q == STEP_CMD;
  assign pop_ready_o = !busy_q || (fire && last_step);
  assign pop         = pop_valid_i && pop_ready_o;

  // Next step: high-order writes only in LBA48 mode
  always_comb begin
    case (step_q)
      STEP_CTRL:   step_next = STEP_DEVSEL;
      STEP_DEVSEL: step_next = cur_q.wide ? STEP_CNT_HI : STEP_CNT_LO;
      STEP_CNT_HI: step_next = STEP_LBA3;
      STEP_LBA3:   step_next = STEP_LBA4;
      STEP_LBA4:   step_next = STEP_LBA5;
      STEP_LBA5:   step_next = STEP_CNT_LO;
      STEP_CNT_LO: step_next = STEP_LBA0;
      STEP_LBA0:   step_next = STEP_LBA1;
      STEP_LBA1:   step_next = STEP_LBA2;
      STEP_LBA2:   step_next = STEP_CMD;
      STEP_CMD:    step_next = STEP_CTRL;
      default:     step_next = STEP_CTRL;
    endcase
  end

  // Register write for the current step
  always_comb begin
    item             = '0;
    item.bus_channel = cur_q.channel;
    case (step_q)
      STEP_CTRL: begin
        item.register_index = REG_CONTROL;
        item.register_data  = CONTROL_NIEN;
      end
      STEP_DEVSEL: begin
        item.register_index = REG_DEVSEL;
        item.register_data  = cur_q.devsel;
      end
      STEP_CNT_HI: item.register_index = REG_COUNT1;
      STEP_LBA3: begin
        item.register_index = REG_LBA3;
        item.register_data  = cur_q.addr_hi;
      end
      STEP_LBA4:   item.register_index = REG_LBA4;
      STEP_LBA5:   item.register_index = REG_LBA5;
      STEP_CNT_LO: begin
        item.register_index = REG_COUNT0;
        item.register_data  = cur_q.count;
      end
      STEP_LBA0: begin
        item.register_index = REG_LBA0;
        item.register_data  = cur_q.byte0;
      end
      STEP_LBA1: begin
        item.register_index = REG_LBA1;
        item.register_data  = cur_q.byte1;
      end
      STEP_LBA2: begin
        item.register_index = REG_LBA2;
        item.register_data  = cur_q.byte2;
      end
      STEP_CMD: begin
        item.register_index = REG_COMMAND;
        item.register_data  = cur_q.command;
        item.last_write     = 1'b1;
      end
      default: item.register_index = REG_CONTROL;
    endcase
  end

  // Sequencer control
  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    rsp_valid_d = fire || (rsp_valid_q && !rsp_ready_i);
    if (pop) begin
      busy_d = 1'b1;
      step_d = STEP_CTRL;
    end else if (fire) begin
      step_d = step_next;
      if (last_step) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_CTRL;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop)  cur_q <= pop_desc_i;
    if (fire) rsp_q <= item;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== dv/ata_taskfile_command_setup_top_test.sv =====
// ----------------------------------------------------------------------------
// ATA task-file command setup: block-level test
// Drives sector access requests into the command setup block, predicts the
// ordered task-file register writes for each one from the drive maps, and
// compares every write leaving the block against the oldest prediction.
// Covers LBA48, LBA28 and CHS addressing, map settings at their extremes,
// random gaps on both sides, a long output stall and fully back-to-back
// traffic.
// ----------------------------------------------------------------------------
module ata_taskfile_command_setup_top_test;
  import ata_tfcs_pkg::*;

  localparam int          CLK_PERIOD        = 8;
  localparam int          RESET_CYCLES      = 8;
  localparam int          DRAIN_CYCLES      = 16;
  localparam int          TIMEOUT_CYCLES    = 200000;
  localparam int          IDLE_PERCENT      = 25;
  localparam logic [1:0]  CFG_UNUSED_IDX    = 2'd3;
  localparam logic [31:0] LBA48_BASE        = 32'h1000_0000;
  localparam logic [31:0] SECTORS_PER_TRACK = 32'd63;
  localparam logic [31:0] HEAD_COUNT        = 32'd16;
  // first address whose cylinder number wraps past 16 bits
  localparam logic [31:0] CYL_WRAP_ADDR     = 32'd66060288;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [3:0] cfg_data;
  logic       req_valid;
  logic       req_ready;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_ready;
  rsp_t       rsp;

  // Predictor copy of the drive maps
  logic [3:0] model_channel_map;
  logic [3:0] model_slave_map;
  logic [3:0] model_lba_map;

  rsp_t       expected_writes[$];
  rsp_t       next_write;
  int         error_count;
  bit         source_gaps_on;
  bit         sink_gaps_on;
  int         sink_hold_cycles;

  ata_taskfile_command_setup_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void queue_write(input logic chan, input reg_idx_e idx,
                                      input logic [7:0] data, input logic last);
    rsp_t w;
    w.bus_channel    = chan;
    w.register_index = idx;
    w.register_data  = data;
    w.last_write     = last;
    expected_writes.push_back(w);
  endfunction

  // Task-file write sequence for one accepted request
  function automatic void predict_taskfile_writes(input req_t r);
    logic        chan;
    logic        slave;
    logic        wide;
    logic [31:0] lba;
    logic [31:0] track;
    logic [31:0] cyl;
    logic [31:0] sect;
    logic [7:0]  devsel;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  cmd;
    lba   = r.block_address;
    chan  = model_channel_map[r.drive_number];
    slave = model_slave_map[r.drive_number];
    wide  = (lba >= LBA48_BASE);
    cmd   = r.transfer_direction ? CMD_WRITE : CMD_READ;
    b0    = lba[7:0];
    b1    = lba[15:8];
    b2    = lba[23:16];
    if (wide) begin
      devsel = DEVSEL_LBA | {3'b000, slave, 4'h0};
      cmd    = cmd | CMD_EXT_FLAG;
    end else if (model_lba_map[r.drive_number]) begin
      devsel = DEVSEL_LBA | {3'b000, slave, lba[27:24]};
    end else begin
      // CHS geometry: 63 sectors per track, 16 heads, cylinder cut to 16 bits
      track  = lba / SECTORS_PER_TRACK;
      sect   = (lba % SECTORS_PER_TRACK) + 32'd1;
      cyl    = track / HEAD_COUNT;
      b0     = sect[7:0];
      b1     = cyl[7:0];
      b2     = cyl[15:8];
      devsel = DEVSEL_CHS | {3'b000, slave, track[3:0]};
    end
    queue_write(chan, REG_CONTROL, CONTROL_NIEN, 1'b0);
    queue_write(chan, REG_DEVSEL, devsel, 1'b0);
    if (wide) begin
      queue_write(chan, REG_COUNT1, 8'h00, 1'b0);
      queue_write(chan, REG_LBA3, lba[31:24], 1'b0);
      queue_write(chan, REG_LBA4, 8'h00, 1'b0);
      queue_write(chan, REG_LBA5, 8'h00, 1'b0);
    end
    queue_write(chan, REG_COUNT0, r.sector_count, 1'b0);
    queue_write(chan, REG_LBA0, b0, 1'b0);
    queue_write(chan, REG_LBA1, b1, 1'b0);
    queue_write(chan, REG_LBA2, b2, 1'b0);
    queue_write(chan, REG_COMMAND, cmd, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Checking of register writes leaving the block
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) begin
      if (expected_writes.size() == 0) begin
        $error("register write with none pending: reg %0d data 0x%0h",
               rsp.register_index, rsp.register_data);
        error_count++;
      end else begin
        next_write = expected_writes.pop_front();
        check_field("bus_channel", next_write.bus_channel, rsp.bus_channel);
        check_field("register_index", next_write.register_index, rsp.register_index);
        check_field("register_data", next_write.register_data, rsp.register_data);
        check_field("last_write", next_write.last_write, rsp.last_write);
      end
    end
  end

  // Receiver: random idling, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else if (sink_hold_cycles > 0) begin
      sink_hold_cycles = sink_hold_cycles - 1;
      rsp_ready <= 1'b0;
    end else if (sink_gaps_on) begin
      rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    int cycles;
    for (cycles = 0; cycles < TIMEOUT_CYCLES; cycles++) @(posedge clk);
    $error("no completion within %0d cycles, %0d writes pending",
           TIMEOUT_CYCLES, expected_writes.size());
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Valid stays high between back-to-back requests; it drops only in gaps and while draining
  task automatic send_request(input req_t item);
    if (source_gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_taskfile_writes(item);
  endtask

  task automatic send_fields(input logic [1:0] drive, input logic dir,
                             input logic [31:0] addr, input logic [7:0] count);
    req_t item;
    item.drive_number       = drive;
    item.transfer_direction = dir;
    item.block_address      = addr;
    item.sector_count       = count;
    send_request(item);
  endtask

  // Block idle: every predicted write seen, plus a margin for the pipeline
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [3:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHANNEL_MAP: model_channel_map = value;
      CFG_SLAVE_MAP:   model_slave_map   = value;
      CFG_LBA_MAP:     model_lba_map     = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_maps(input logic [3:0] chan, input logic [3:0] slave,
                            input logic [3:0] lba);
    write_config(CFG_CHANNEL_MAP, chan);
    write_config(CFG_SLAVE_MAP, slave);
    write_config(CFG_LBA_MAP, lba);
  endtask

  // Address mix: full range, LBA28 range, CHS origin, mode boundary, cylinder wrap
  function automatic req_t draw_request();
    req_t r;
    r.drive_number       = 2'($urandom_range(0, 3));
    r.transfer_direction = 1'($urandom_range(0, 1));
    r.sector_count       = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0, 1: r.block_address = $urandom();
      2, 3: r.block_address = $urandom() & 32'h0FFF_FFFF;
      4:    r.block_address = $urandom_range(0, 4095);
      5:    r.block_address = LBA48_BASE - 32'd32 + $urandom_range(0, 63);
      default: r.block_address = CYL_WRAP_ADDR - 32'd1024 + $urandom_range(0, 2047);
    endcase
    return r;
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_request(draw_request());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset maps: LBA28 and LBA48 with field extremes on every drive
  task automatic test_directed_lba();
    send_fields(2'd0, 1'b0, 32'h0000_0000, 8'h00);
    send_fields(2'd1, 1'b1, 32'h0FFF_FFFF, 8'hFF);
    send_fields(2'd2, 1'b0, LBA48_BASE, 8'h01);
    send_fields(2'd3, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_fields(2'd0, 1'b1, 32'h0ABC_DEF1, 8'h5A);
    send_fields(2'd3, 1'b0, 32'h8765_4321, 8'hA5);
    wait_drained();
  endtask

  // CHS conversion: track and head boundaries, cylinder wrap, LBA48 override
  task automatic test_directed_chs();
    write_config(CFG_LBA_MAP, 4'h0);
    send_fields(2'd0, 1'b0, 32'd0, 8'h00);
    send_fields(2'd1, 1'b1, 32'd62, 8'h01);
    send_fields(2'd2, 1'b0, 32'd63, 8'h02);
    send_fields(2'd3, 1'b1, 32'd1007, 8'h03);
    send_fields(2'd0, 1'b0, 32'd1008, 8'h04);
    send_fields(2'd1, 1'b1, CYL_WRAP_ADDR, 8'h05);
    send_fields(2'd2, 1'b0, 32'h0FFF_FFFF, 8'hFF);
    send_fields(2'd3, 1'b1, LBA48_BASE, 8'h07);
    wait_drained();
    // channel and slave maps at opposite extremes
    write_maps(4'hF, 4'h0, 4'hF);
    send_fields(2'd1, 1'b0, 32'h0123_4567, 8'h10);
    send_fields(2'd2, 1'b1, 32'h2000_0000, 8'h20);
    wait_drained();
    write_maps(4'h0, 4'hF, 4'h0);
    send_fields(2'd3, 1'b0, 32'h0000_9876, 8'h30);
    send_fields(2'd0, 1'b1, 32'hF000_0001, 8'h40);
    wait_drained();
    // unmapped register index must change nothing
    write_config(CFG_UNUSED_IDX, 4'hF);
    send_fields(2'd2, 1'b0, 32'h0000_1234, 8'h50);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_maps(4'h0, 4'h0, 4'h0);
    send_random(30);
    wait_drained();
    write_maps(4'hF, 4'hF, 4'hF);
    send_random(30);
    wait_drained();
    write_maps(CHANNEL_MAP_RST, SLAVE_MAP_RST, 4'h5);
    send_random(30);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      write_maps(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)));
      send_random(45);
      wait_drained();
    end
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_backpressure();
    source_gaps_on   = 1'b0;
    sink_hold_cycles = 300;
    send_random(30);
    source_gaps_on = 1'b1;
    wait_drained();
  endtask

  // Sender stops until every write of the first batch has come out
  task automatic test_sender_pause();
    send_random(10);
    wait_drained();
    send_random(10);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    source_gaps_on = 1'b0;
    sink_gaps_on   = 1'b0;
    send_random(40);
    wait_drained();
    source_gaps_on = 1'b1;
    sink_gaps_on   = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_CHANNEL_MAP;
    cfg_data          = 4'h0;
    req_valid         = 1'b0;
    req               = '0;
    rsp_ready         = 1'b0;
    error_count       = 0;
    source_gaps_on    = 1'b1;
    sink_gaps_on      = 1'b1;
    sink_hold_cycles  = 0;
    model_channel_map = CHANNEL_MAP_RST;
    model_slave_map   = SLAVE_MAP_RST;
    model_lba_map     = LBA_MAP_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_lba();
    test_directed_chs();
    test_config_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    test_back_to_back();

    wait_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ata_tfcs_pkg.sv
rtl/core/ata_tfcs_front.sv
rtl/core/ata_tfcs_queue.sv
rtl/core/ata_tfcs_back.sv
rtl/core/ata_tfcs_top.sv
dv/ata_taskfile_command_setup_top_test.sv
